### hw/rtl/dwt1d_pkg.sv
`default_nettype none
package dwt1d_pkg;

  localparam int MAX_LENGTH_DEF = 64;
  localparam int MAX_TAPS_DEF   = 6;

  localparam int DATA_W    = 32;
  localparam int TAP_W     = 16;
  localparam int PROD_W    = DATA_W + TAP_W;
  localparam int ACC_W     = PROD_W + 4;
  localparam int CFG_W     = 7;
  localparam int CFG_IDX_W = 3;
  localparam int LVL_W     = 3;
  localparam int KIND_W    = 2;
  localparam int TLEN_W    = 3;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_FILTER_KIND = 3'd0,
    REG_LEVELS      = 3'd1,
    REG_INVERSE     = 3'd2,
    REG_TAPS_STORED = 3'd3,
    REG_ORIG_LEN    = 3'd4
  } cfg_reg_t;

  localparam logic [KIND_W-1:0] KIND_HAAR = 2'd0;
  localparam logic [KIND_W-1:0] KIND_DB2  = 2'd1;
  localparam logic [KIND_W-1:0] KIND_DB3  = 2'd2;

  localparam logic [1:0] BANK_LO  = 2'd0;
  localparam logic [1:0] BANK_HI  = 2'd1;
  localparam logic [1:0] BANK_ILO = 2'd2;
  localparam logic [1:0] BANK_IHI = 2'd3;

  typedef logic signed [TAP_W-1:0] tap_t;

  typedef struct packed {
    logic clr;
    logic mul;
    logic acc;
  } mac_ctrl_t;

  localparam tap_t HAAR_TAPS [4][6] = '{
    '{16'sd23170, 16'sd23170, 16'sd0, 16'sd0, 16'sd0, 16'sd0},
    '{-16'sd23170, 16'sd23170, 16'sd0, 16'sd0, 16'sd0, 16'sd0},
    '{16'sd23170, 16'sd23170, 16'sd0, 16'sd0, 16'sd0, 16'sd0},
    '{16'sd23170, -16'sd23170, 16'sd0, 16'sd0, 16'sd0, 16'sd0}
  };

  localparam tap_t DB2_TAPS [4][6] = '{
    '{-16'sd4240, 16'sd7345, 16'sd27411, 16'sd15826, 16'sd0, 16'sd0},
    '{-16'sd15826, 16'sd27411, -16'sd7345, -16'sd4240, 16'sd0, 16'sd0},
    '{16'sd15826, 16'sd27411, 16'sd7345, -16'sd4240, 16'sd0, 16'sd0},
    '{-16'sd4240, -16'sd7345, 16'sd27411, -16'sd15826, 16'sd0, 16'sd0}
  };

  localparam tap_t DB3_TAPS [4][6] = '{
    '{16'sd1154, -16'sd2800, -16'sd4424, 16'sd15069, 16'sd26440, 16'sd10901},
    '{-16'sd10901, 16'sd26440, -16'sd15069, -16'sd4424, 16'sd2800, 16'sd1154},
    '{16'sd10901, 16'sd26440, 16'sd15069, -16'sd4424, -16'sd2800, 16'sd1154},
    '{16'sd1154, 16'sd2800, -16'sd4424, -16'sd15069, 16'sd26440, -16'sd10901}
  };

  function automatic logic [TLEN_W-1:0] tap_len(input logic [KIND_W-1:0] kind);
    logic [TLEN_W-1:0] l;
    case (kind)
      KIND_HAAR: l = 3'd2;
      KIND_DB2:  l = 3'd4;
      default:   l = 3'd6;
    endcase
    return l;
  endfunction

  function automatic tap_t tap_value(input logic [KIND_W-1:0] kind, input logic [1:0] bank,
                                     input logic [TLEN_W-1:0] idx);
    tap_t v;
    v = '0;
    if (idx < 3'd6) begin
      case (kind)
        KIND_HAAR: v = HAAR_TAPS[bank][idx];
        KIND_DB2:  v = DB2_TAPS[bank][idx];
        default:   v = DB3_TAPS[bank][idx];
      endcase
    end
    return v;
  endfunction

endpackage
`default_nettype wire

### hw/rtl/dwt1d_if.sv
`default_nettype none
interface dwt1d_in_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] sample_value;
  logic               last_sample;
  modport source (output valid, output sample_value, output last_sample, input ready);
  modport sink (input valid, input sample_value, input last_sample, output ready);
endinterface

interface dwt1d_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] result_value;
  logic               last_result;
  logic               level_error;
  modport source (output valid, output result_value, output last_result, output level_error,
                  input ready);
  modport sink (input valid, input result_value, input last_result, input level_error,
                output ready);
endinterface
`default_nettype wire

### hw/rtl/dwt1d_mac.sv
`default_nettype none
module dwt1d_mac (
  input  wire                                clk,
  input  dwt1d_pkg::mac_ctrl_t               ctrl,
  input  wire  signed [dwt1d_pkg::DATA_W-1:0] data,
  input  dwt1d_pkg::tap_t                    tap,
  output logic signed [dwt1d_pkg::DATA_W-1:0] sat_value
);
  import dwt1d_pkg::*;

  localparam int SH_W = ACC_W - 15;

  logic signed [PROD_W-1:0] prod_r;
  logic signed [ACC_W-1:0]  acc_r;
  logic signed [ACC_W-1:0]  rnd;
  logic signed [SH_W-1:0]   shifted;

  always_ff @(posedge clk) begin
    if (ctrl.mul) prod_r <= data * tap;
    if (ctrl.clr) acc_r <= '0;
    else if (ctrl.acc) acc_r <= acc_r + ACC_W'(prod_r);
  end

  assign rnd     = acc_r + ACC_W'(16384);
  assign shifted = rnd[ACC_W-1:15];

  always_comb begin
    if (shifted > SH_W'(64'sd2147483647)) sat_value = 32'sh7fffffff;
    else if (shifted < -SH_W'(64'sd2147483648)) sat_value = 32'sh80000000;
    else sat_value = shifted[DATA_W-1:0];
  end
endmodule
`default_nettype wire

### hw/rtl/dwt_1d_multilevel_unit.sv
// Load: one sample transaction per cycle; the last one starts the transform once the work memory
// is zero-padded up to N, the padded power-of-two length, and a forward level count is checked.
// Each forward level on n values and each inverse level giving n values reads, multiplies,
// accumulates and writes every term through the single shared multiply-accumulate.
// Results then leave one at a time, each held until the sink is ready before the next is read.
// Reset (synchronous, active low) restores register defaults and the load count, not the memories.
`default_nettype none
module dwt_1d_multilevel_unit #(
  parameter int MAX_LENGTH = dwt1d_pkg::MAX_LENGTH_DEF,
  parameter int MAX_TAPS   = dwt1d_pkg::MAX_TAPS_DEF
) (
  input  wire                             clk,
  input  wire                             rst_n,
  dwt1d_in_if.sink                        in_ch,
  dwt1d_out_if.source                     out_ch,
  input  wire                             cfg_we,
  input  wire [dwt1d_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire [dwt1d_pkg::CFG_W-1:0]      cfg_data
);
  import dwt1d_pkg::*;

  localparam int AW    = (MAX_LENGTH > 1) ? $clog2(MAX_LENGTH) : 1;
  localparam int DEPTH = 1 << AW;
  localparam int CW    = AW + 1;
  localparam int TW    = $clog2(2 * MAX_TAPS);

  typedef enum logic [13:0] {
    S_LOAD = 14'b00000000000001,
    S_PAD  = 14'b00000000000010,
    S_CHK  = 14'b00000000000100,
    S_LVL  = 14'b00000000001000,
    S_RD   = 14'b00000000010000,
    S_MUL  = 14'b00000000100000,
    S_ACC  = 14'b00000001000000,
    S_WR   = 14'b00000010000000,
    S_CPR  = 14'b00000100000000,
    S_CPW  = 14'b00001000000000,
    S_ORD  = 14'b00010000000000,
    S_OLD  = 14'b00100000000000,
    S_ERR  = 14'b01000000000000,
    S_OWT  = 14'b10000000000000
  } state_t;

  state_t state_r, state_nxt;

  logic [KIND_W-1:0] kind_r;
  logic [LVL_W-1:0]  levels_r;
  logic              inv_r, stored_r;
  logic [CFG_W-1:0]  orig_r;

  logic [CW-1:0]    cnt_r, cnt_nxt, nlen_r, nlen_nxt, n_r, n_nxt, half_r, half_nxt;
  logic [CW-1:0]    o_r, o_nxt, count_r, count_nxt;
  logic [LVL_W-1:0] lvl_r, lvl_nxt;
  logic [TW-1:0]    t_r, t_nxt;
  tap_t             tap_r, tap_nxt;

  logic              out_valid_r, out_valid_nxt, out_last_r, out_last_nxt;
  logic              out_err_r, out_err_nxt;
  logic [DATA_W-1:0] out_value_r, out_value_nxt;

  logic [DATA_W-1:0] work_mem [DEPTH];
  logic [DATA_W-1:0] scr_mem [DEPTH];
  logic [DATA_W-1:0] work_rd_r, scr_rd_r;
  logic              wk_we, wk_re, sc_we, sc_re;
  logic [AW-1:0]     wk_wa, wk_ra, sc_a;
  logic [DATA_W-1:0] wk_wd;

  mac_ctrl_t         mac;
  logic signed [DATA_W-1:0] sat_value;

  logic [KIND_W-1:0] kind_eff;
  logic [TLEN_W-1:0] len, j, tidx;
  logic              sub, hi_band, skip, term_last;
  logic [CW-1:0]     fi, c_after, nlen_calc, lvl_shift;
  logic [CW:0]       fwd_sum;
  logic [AW-1:0]     mask, k, fwd_addr, inv_addr, term_addr;
  logic [1:0]        bank;
  logic [LVL_W-1:0]  err_sh;
  logic              lvl_error;
  logic [CFG_W-1:0]  clamp_len;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      kind_r   <= KIND_HAAR;
      levels_r <= 3'd1;
      inv_r    <= 1'b0;
      stored_r <= 1'b0;
      orig_r   <= 7'd64;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_FILTER_KIND: kind_r   <= cfg_data[KIND_W-1:0];
        REG_LEVELS:      levels_r <= cfg_data[LVL_W-1:0];
        REG_INVERSE:     inv_r    <= cfg_data[0];
        REG_TAPS_STORED: stored_r <= cfg_data[0];
        REG_ORIG_LEN:    orig_r   <= cfg_data;
        default: ;
      endcase
    end
  end

  assign kind_eff  = (kind_r == 2'd3) ? KIND_DB3 : kind_r;
  assign len       = tap_len(kind_eff);
  assign j         = inv_r ? TLEN_W'(t_r >> 1) : TLEN_W'(t_r);
  assign sub       = t_r[0];
  assign term_last = inv_r ? (t_r == TW'({len - 3'd1, 1'b1})) : (t_r == TW'(len - 3'd1));
  assign hi_band   = (o_r >= half_r);
  assign fi        = hi_band ? (o_r - half_r) : o_r;
  assign mask      = AW'(n_r - CW'(1));
  assign fwd_sum   = {fi, 1'b1} + (CW+1)'(j) + (CW+1)'(n_r) - (CW+1)'(len - 3'd1);
  assign fwd_addr  = fwd_sum[AW-1:0] & mask;
  assign k         = (o_r[AW-1:0] + AW'(j)) & mask;
  assign inv_addr  = sub ? (half_r[AW-1:0] + (k >> 1)) : (k >> 1);
  assign skip      = inv_r && !k[0];
  assign term_addr = inv_r ? inv_addr : fwd_addr;
  assign bank      = inv_r ? (sub ? BANK_IHI : BANK_ILO) : (hi_band ? BANK_HI : BANK_LO);
  assign tidx      = stored_r ? j : (len - 3'd1 - j);

  assign c_after   = cnt_r + ((cnt_r < CW'(MAX_LENGTH)) ? CW'(1) : CW'(0));
  always_comb begin
    nlen_calc = CW'(2);
    for (int b = 1; b < AW; b++) begin
      if (nlen_calc < c_after) nlen_calc = nlen_calc << 1;
    end
  end

  assign lvl_shift = nlen_r >> lvl_r;
  assign err_sh    = (levels_r == '0) ? '0 : (levels_r - 3'd1);
  assign lvl_error = (CFG_W'(nlen_r >> err_sh) < CFG_W'(len));

  always_comb begin
    clamp_len = orig_r;
    if (clamp_len == '0) clamp_len = CFG_W'(1);
    if (clamp_len > CFG_W'(nlen_r)) clamp_len = CFG_W'(nlen_r);
  end

  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    nlen_nxt      = nlen_r;
    n_nxt         = n_r;
    half_nxt      = half_r;
    lvl_nxt       = lvl_r;
    o_nxt         = o_r;
    t_nxt         = t_r;
    count_nxt     = count_r;
    tap_nxt       = tap_r;
    out_valid_nxt = out_valid_r;
    out_value_nxt = out_value_r;
    out_last_nxt  = out_last_r;
    out_err_nxt   = out_err_r;
    mac           = '0;
    wk_we         = 1'b0;
    wk_wa         = o_r[AW-1:0];
    wk_wd         = '0;
    wk_re         = 1'b0;
    wk_ra         = o_r[AW-1:0];
    sc_we         = 1'b0;
    sc_re         = 1'b0;
    sc_a          = o_r[AW-1:0];
    unique case (state_r)
      S_LOAD: begin
        if (in_ch.valid) begin
          if (cnt_r < CW'(MAX_LENGTH)) begin
            wk_we   = 1'b1;
            wk_wa   = cnt_r[AW-1:0];
            wk_wd   = in_ch.sample_value;
            cnt_nxt = cnt_r + CW'(1);
          end
          if (in_ch.last_sample) begin
            cnt_nxt   = '0;
            nlen_nxt  = nlen_calc;
            o_nxt     = c_after;
            state_nxt = S_PAD;
          end
        end
      end
      S_PAD: begin
        if (o_r >= nlen_r) begin
          state_nxt = S_CHK;
        end else begin
          wk_we = 1'b1;
          o_nxt = o_r + CW'(1);
        end
      end
      S_CHK: begin
        if (!inv_r) begin
          lvl_nxt   = '0;
          state_nxt = lvl_error ? S_ERR : S_LVL;
        end else begin
          lvl_nxt   = levels_r;
          state_nxt = S_LVL;
        end
      end
      S_LVL: begin
        o_nxt = '0;
        t_nxt = '0;
        if (!inv_r) begin
          if (lvl_r == levels_r) begin
            count_nxt = nlen_r;
            state_nxt = S_ORD;
          end else begin
            n_nxt     = lvl_shift;
            half_nxt  = lvl_shift >> 1;
            mac.clr   = 1'b1;
            state_nxt = S_RD;
          end
        end else begin
          if (lvl_r == '0) begin
            count_nxt = CW'(clamp_len);
            state_nxt = S_ORD;
          end else if (lvl_shift == '0) begin
            lvl_nxt = lvl_r - 3'd1;
          end else begin
            n_nxt     = lvl_shift << 1;
            half_nxt  = lvl_shift;
            mac.clr   = 1'b1;
            state_nxt = S_RD;
          end
        end
      end
      S_RD: begin
        if (skip) begin
          if (term_last) state_nxt = S_WR;
          else t_nxt = t_r + TW'(1);
        end else begin
          wk_re     = 1'b1;
          wk_ra     = term_addr;
          tap_nxt   = tap_value(kind_eff, bank, tidx);
          state_nxt = S_MUL;
        end
      end
      S_MUL: begin
        mac.mul   = 1'b1;
        state_nxt = S_ACC;
      end
      S_ACC: begin
        mac.acc = 1'b1;
        if (term_last) begin
          state_nxt = S_WR;
        end else begin
          t_nxt     = t_r + TW'(1);
          state_nxt = S_RD;
        end
      end
      S_WR: begin
        sc_we = 1'b1;
        if (o_r == n_r - CW'(1)) begin
          o_nxt     = '0;
          state_nxt = S_CPR;
        end else begin
          o_nxt     = o_r + CW'(1);
          t_nxt     = '0;
          mac.clr   = 1'b1;
          state_nxt = S_RD;
        end
      end
      S_CPR: begin
        sc_re     = 1'b1;
        state_nxt = S_CPW;
      end
      S_CPW: begin
        wk_we = 1'b1;
        wk_wd = scr_rd_r;
        if (o_r == n_r - CW'(1)) begin
          lvl_nxt   = inv_r ? (lvl_r - 3'd1) : (lvl_r + 3'd1);
          state_nxt = S_LVL;
        end else begin
          o_nxt     = o_r + CW'(1);
          state_nxt = S_CPR;
        end
      end
      S_ORD: begin
        wk_re     = 1'b1;
        state_nxt = S_OLD;
      end
      S_OLD: begin
        out_valid_nxt = 1'b1;
        out_value_nxt = work_rd_r;
        out_last_nxt  = (o_r == count_r - CW'(1));
        out_err_nxt   = 1'b0;
        state_nxt     = S_OWT;
      end
      S_ERR: begin
        out_valid_nxt = 1'b1;
        out_value_nxt = '0;
        out_last_nxt  = 1'b1;
        out_err_nxt   = 1'b1;
        state_nxt     = S_OWT;
      end
      S_OWT: begin
        if (out_ch.ready) begin
          out_valid_nxt = 1'b0;
          if (out_last_r) begin
            state_nxt = S_LOAD;
          end else begin
            o_nxt     = o_r + CW'(1);
            state_nxt = S_ORD;
          end
        end
      end
      default: state_nxt = S_LOAD;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_LOAD;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    nlen_r      <= nlen_nxt;
    n_r         <= n_nxt;
    half_r      <= half_nxt;
    lvl_r       <= lvl_nxt;
    o_r         <= o_nxt;
    t_r         <= t_nxt;
    count_r     <= count_nxt;
    tap_r       <= tap_nxt;
    out_value_r <= out_value_nxt;
    out_last_r  <= out_last_nxt;
    out_err_r   <= out_err_nxt;
  end

  always_ff @(posedge clk) begin
    if (wk_we) work_mem[wk_wa] <= wk_wd;
    if (wk_re) work_rd_r <= work_mem[wk_ra];
  end

  always_ff @(posedge clk) begin
    if (sc_we) scr_mem[sc_a] <= sat_value;
    if (sc_re) scr_rd_r <= scr_mem[sc_a];
  end

  dwt1d_mac u_mac (
    .clk       (clk),
    .ctrl      (mac),
    .data      (work_rd_r),
    .tap       (tap_r),
    .sat_value (sat_value)
  );

  assign in_ch.ready         = (state_r == S_LOAD);
  assign out_ch.valid        = out_valid_r;
  assign out_ch.result_value = out_value_r;
  assign out_ch.last_result  = out_last_r;
  assign out_ch.level_error  = out_err_r;
endmodule
`default_nettype wire

### hw/rtl/dwt1d_checker.sv
`default_nettype none
module dwt1d_checker (
  input wire        clk,
  input wire        rst_n,
  input wire        in_ready,
  input wire        out_valid,
  input wire        out_ready,
  input wire [31:0] out_value,
  input wire        out_last,
  input wire        out_err
);
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_value) && $stable(out_last)
      && $stable(out_err))
    else $error("result changed while stalled");

  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_ready && out_valid))
    else $error("loading while a result is pending");

  a_err_form: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_err |-> out_last && (out_value == 32'd0))
    else $error("malformed error result");

  a_run_end: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && out_last |=> !out_valid && in_ready)
    else $error("block not back to loading after last result");

  a_reset: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid after reset");
endmodule

bind dwt_1d_multilevel_unit dwt1d_checker u_dwt1d_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_ready  (in_ch.ready),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .out_value (out_ch.result_value),
  .out_last  (out_ch.last_result),
  .out_err   (out_ch.level_error)
);
`default_nettype wire

### dv/dwt_1d_multilevel_unit_test.sv
`default_nettype none
module dwt_1d_multilevel_unit_test;
  timeunit 1ns;
  timeprecision 1ps;
  import dwt1d_pkg::*;

  typedef struct {
    logic signed [31:0] value;
    logic               last;
    logic               err;
  } coeff_t;

  typedef struct {
    int     n;
    coeff_t r[2];
  } typed_t;

  typedef enum int {ROW_CFG, ROW_SAMPLE} row_kind_t;

  typedef struct {
    row_kind_t          kind;
    cfg_reg_t           idx;
    int                 data;
    logic signed [31:0] value;
    logic               last;
    typed_t             exp;
  } row_t;

  localparam int CYCLE_LIMIT = 3000000;
  localparam int SETTLE = 40;

  localparam int TAPS [3][4][6] = '{
    '{'{23170, 23170, 0, 0, 0, 0}, '{-23170, 23170, 0, 0, 0, 0},
      '{23170, 23170, 0, 0, 0, 0}, '{23170, -23170, 0, 0, 0, 0}},
    '{'{-4240, 7345, 27411, 15826, 0, 0}, '{-15826, 27411, -7345, -4240, 0, 0},
      '{15826, 27411, 7345, -4240, 0, 0}, '{-4240, -7345, 27411, -15826, 0, 0}},
    '{'{1154, -2800, -4424, 15069, 26440, 10901},
      '{-10901, 26440, -15069, -4424, 2800, 1154},
      '{10901, 26440, 15069, -4424, -2800, 1154},
      '{1154, 2800, -4424, -15069, 26440, -10901}}
  };
  localparam int TAP_COUNT [3] = '{2, 4, 6};

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_W-1:0] cfg_data;

  dwt1d_in_if in_ch();
  dwt1d_out_if out_ch();

  dwt_1d_multilevel_unit uut (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch.sink), .out_ch(out_ch.source),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  // predictor state
  logic [1:0] m_kind;
  logic [2:0] m_levels;
  logic       m_inverse;
  logic       m_stored;
  logic [6:0] m_orig_len;
  longint     signal_buf [64];
  longint     band_buf [64];
  int         load_count;

  coeff_t coeff_q[$];
  typed_t typed_q[$];

  int  failures;
  int  cycle_count;
  int  in_idle_pct;
  int  out_stall_pct;
  logic hold_req;
  logic hold_done;
  int  hold_left;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("dwt_1d_multilevel_unit test failed");
      $finish;
    end
  end

  function automatic int kind_eff();
    return (m_kind > 2) ? 2 : int'(m_kind);
  endfunction

  function automatic longint tap_at(int bank, int j);
    int k;
    int idx;
    k = kind_eff();
    idx = m_stored ? j : TAP_COUNT[k] - 1 - j;
    if (idx >= 6) idx = 0;
    return longint'(TAPS[k][bank][idx]);
  endfunction

  function automatic longint q15_round_sat(longint acc);
    longint r;
    r = (acc + 64'sd16384) >>> 15;
    if (r > 64'sd2147483647) r = 64'sd2147483647;
    if (r < -64'sd2147483648) r = -64'sd2147483648;
    return r;
  endfunction

  function automatic void analysis_level(int n, int len);
    int half;
    longint lo;
    longint hi;
    longint x;
    half = n / 2;
    for (int i = 0; i < half; i++) begin
      lo = 0;
      hi = 0;
      for (int j = 0; j < len; j++) begin
        x = signal_buf[(2 * i + 1 + j + n - (len - 1)) % n];
        lo += x * tap_at(BANK_LO, j);
        hi += x * tap_at(BANK_HI, j);
      end
      band_buf[i] = q15_round_sat(lo);
      band_buf[half + i] = q15_round_sat(hi);
    end
    for (int i = 0; i < n; i++) signal_buf[i] = band_buf[i];
  endfunction

  function automatic void synthesis_level(int r, int len);
    int n;
    int k;
    int s;
    longint acc;
    n = 2 * r;
    for (int m = 0; m < n; m++) begin
      acc = 0;
      for (int j = 0; j < len; j++) begin
        k = (m + j) % n;
        if (k % 2 == 1) begin
          s = (k - 1) / 2;
          acc += signal_buf[s] * tap_at(BANK_ILO, j) + signal_buf[r + s] * tap_at(BANK_IHI, j);
        end
      end
      band_buf[m] = q15_round_sat(acc);
    end
    for (int m = 0; m < n; m++) signal_buf[m] = band_buf[m];
  endfunction

  function automatic void predict_sample(logic signed [31:0] v, logic last, ref coeff_t res[$]);
    int n;
    int len;
    int shift;
    int count;
    coeff_t c;
    res.delete();
    if (load_count < 64) begin
      signal_buf[load_count] = longint'(v);
      load_count++;
    end
    if (!last) return;
    n = 2;
    while (n < load_count) n *= 2;
    for (int i = load_count; i < n; i++) signal_buf[i] = 0;
    load_count = 0;
    len = TAP_COUNT[kind_eff()];
    if (!m_inverse) begin
      shift = (m_levels == 0) ? 0 : int'(m_levels) - 1;
      if ((n >> shift) < len) begin
        c.value = '0;
        c.last = 1'b1;
        c.err = 1'b1;
        res = {res, c};
        return;
      end
      for (int i = 0; i < m_levels; i++) analysis_level(n >> i, len);
      count = n;
    end else begin
      for (int i = m_levels; i > 0; i--) if ((n >> i) > 0) synthesis_level(n >> i, len);
      count = m_orig_len;
      if (count < 1) count = 1;
      if (count > n) count = n;
    end
    for (int i = 0; i < count; i++) begin
      c.value = signal_buf[i][31:0];
      c.last = (i + 1 == count);
      c.err = 1'b0;
      res = {res, c};
    end
  endfunction

  // input transactions: run the predictor, and take the typed expectation instead where one is given
  always @(posedge clk) begin
    coeff_t res[$];
    typed_t t;
    if (rst_n && in_ch.valid && in_ch.ready) begin
      predict_sample(in_ch.sample_value, in_ch.last_sample, res);
      t = typed_q.pop_front();
      if (t.n > 0) begin
        for (int i = 0; i < t.n; i++) coeff_q = {coeff_q, t.r[i]};
      end else begin
        foreach (res[i]) coeff_q = {coeff_q, res[i]};
      end
    end
  end

  always @(posedge clk) begin
    coeff_t e;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (coeff_q.size() == 0) begin
        $error("unexpected result transaction value=%0d", out_ch.result_value);
        failures++;
      end else begin
        e = coeff_q.pop_front();
        if (out_ch.result_value !== e.value) begin
          $error("result_value expected %0d actual %0d", e.value, out_ch.result_value);
          failures++;
        end
        if (out_ch.last_result !== e.last) begin
          $error("last_result expected %0b actual %0b", e.last, out_ch.last_result);
          failures++;
        end
        if (out_ch.level_error !== e.err) begin
          $error("level_error expected %0b actual %0b", e.err, out_ch.level_error);
          failures++;
        end
      end
    end
  end

  // sink side, with the one long hold-off
  always @(posedge clk) begin
    if (hold_req && !hold_done) begin
      hold_done <= 1'b1;
      hold_left <= 3000;
      out_ch.ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= ($urandom_range(99) >= out_stall_pct);
    end
  end

  task automatic wait_idle();
    @(posedge clk);
    while (coeff_q.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_reg(cfg_reg_t idx, int data);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data[CFG_W-1:0];
    case (idx)
      REG_FILTER_KIND: m_kind = data[1:0];
      REG_LEVELS:      m_levels = data[2:0];
      REG_INVERSE:     m_inverse = data[0];
      REG_TAPS_STORED: m_stored = data[0];
      REG_ORIG_LEN:    m_orig_len = data[6:0];
      default: ;
    endcase
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  task automatic send_sample(logic signed [31:0] v, logic last, typed_t t);
    while ($urandom_range(99) < in_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    typed_q = {typed_q, t};
    in_ch.valid <= 1'b1;
    in_ch.sample_value <= v;
    in_ch.last_sample <= last;
    @(posedge clk iff in_ch.ready);
  endtask

  function automatic logic signed [31:0] rand_sample();
    int sel;
    sel = $urandom_range(3);
    if (sel == 0) return $urandom;
    return $signed($urandom_range(8191)) - 4096;
  endfunction

  task automatic random_config();
    int lvl;
    lvl = ($urandom_range(99) < 80) ? $urandom_range(1, 3) : $urandom_range(0, 7);
    write_reg(REG_FILTER_KIND, $urandom_range(3));
    write_reg(REG_LEVELS, lvl);
    write_reg(REG_INVERSE, $urandom_range(1));
    write_reg(REG_TAPS_STORED, $urandom_range(1));
    write_reg(REG_ORIG_LEN, ($urandom_range(3) == 0) ? $urandom_range(127) : $urandom_range(1, 16));
  endtask

  task automatic send_signal(ref int sent);
    int len;
    int sel;
    typed_t none;
    none.n = 0;
    sel = $urandom_range(99);
    len = (sel < 70) ? $urandom_range(1, 16) : (sel < 93) ? $urandom_range(17, 64)
                                                          : $urandom_range(65, 70);
    for (int i = 0; i < len; i++) send_sample(rand_sample(), i == len - 1, none);
    sent += len;
  endtask

  function automatic row_t cfg_row(cfg_reg_t idx, int data);
    row_t r;
    r.kind = ROW_CFG;
    r.idx = idx;
    r.data = data;
    r.value = '0;
    r.last = 1'b0;
    r.exp.n = 0;
    return r;
  endfunction

  function automatic row_t smp_row(logic signed [31:0] v, logic last, int n = 0,
                                   logic signed [31:0] v0 = 0, logic signed [31:0] v1 = 0,
                                   logic err = 1'b0);
    row_t r;
    r.kind = ROW_SAMPLE;
    r.idx = REG_FILTER_KIND;
    r.data = 0;
    r.value = v;
    r.last = last;
    r.exp.n = n;
    r.exp.r[0].value = v0;
    r.exp.r[0].last = (n == 1);
    r.exp.r[0].err = err;
    r.exp.r[1].value = v1;
    r.exp.r[1].last = 1'b1;
    r.exp.r[1].err = 1'b0;
    return r;
  endfunction

  initial begin
    row_t rows[$];
    int sent;
    int phase_in [4] = '{0, 51, 0, 30};
    int phase_out [4] = '{0, 0, 51, 30};

    failures = 0;
    cycle_count = 0;
    hold_req = 1'b0;
    hold_done = 1'b0;
    hold_left = 0;
    in_idle_pct = 0;
    out_stall_pct = 0;
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    in_ch.valid = 1'b0;
    in_ch.sample_value = '0;
    in_ch.last_sample = 1'b0;
    out_ch.ready = 1'b0;
    m_kind = '0;
    m_levels = 3'd1;
    m_inverse = 1'b0;
    m_stored = 1'b0;
    m_orig_len = 7'd64;
    load_count = 0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // after reset: Haar, one forward level
    rows = {rows, smp_row(256, 0)};
    rows = {rows, smp_row(256, 1, 2, 362, 0)};
    rows = {rows, smp_row(32'sh7fffffff, 0)};
    rows = {rows, smp_row(32'sh7fffffff, 1, 2, 32'sh7fffffff, 0)};
    rows = {rows, smp_row(32'sh80000000, 0)};
    rows = {rows, smp_row(32'sh80000000, 1, 2, 32'sh80000000, 0)};
    // no levels: padded signal passes through
    rows = {rows, cfg_row(REG_LEVELS, 0)};
    rows = {rows, smp_row(5, 1, 2, 5, 0)};
    // too many levels
    rows = {rows, cfg_row(REG_LEVELS, 6)};
    rows = {rows, smp_row(7, 1, 1, 0, 0, 1'b1)};
    // unused filter code (taken as db3), stored taps
    rows = {rows, cfg_row(REG_FILTER_KIND, 3)};
    rows = {rows, cfg_row(REG_LEVELS, 2)};
    rows = {rows, cfg_row(REG_TAPS_STORED, 1)};
    for (int i = 0; i < 8; i++) rows = {rows, smp_row(i * 1000 - 3000, i == 7)};
    // inverse, levels beyond the band length, crop length zero
    rows = {rows, cfg_row(REG_INVERSE, 1)};
    rows = {rows, cfg_row(REG_FILTER_KIND, KIND_DB2)};
    rows = {rows, cfg_row(REG_LEVELS, 7)};
    rows = {rows, cfg_row(REG_ORIG_LEN, 0)};
    rows = {rows, smp_row(-77, 0)};
    rows = {rows, smp_row(4096, 1)};

    foreach (rows[i]) begin
      if (rows[i].kind == ROW_CFG) begin
        in_ch.valid <= 1'b0;
        wait_idle();
        write_reg(rows[i].idx, rows[i].data);
      end else begin
        send_sample(rows[i].value, rows[i].last, rows[i].exp);
      end
    end
    in_ch.valid <= 1'b0;

    for (int p = 0; p < 4; p++) begin
      wait_idle();
      in_idle_pct = phase_in[p];
      out_stall_pct = phase_out[p];
      sent = 0;
      if (p == 0) begin
        random_config();
        write_reg(REG_INVERSE, 0);
        write_reg(REG_LEVELS, 1);
        hold_req <= 1'b1;
        for (int s = 0; s < 4; s++) send_signal(sent);
      end
      while (sent < 120) begin
        in_ch.valid <= 1'b0;
        wait_idle();
        random_config();
        send_signal(sent);
      end
      in_ch.valid <= 1'b0;
    end

    @(posedge clk);
    while (coeff_q.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    if (failures == 0 && coeff_q.size() == 0) begin
      $display("dwt_1d_multilevel_unit test passed");
    end else begin
      $display("dwt_1d_multilevel_unit test failed");
    end
    $finish;
  end

endmodule
`default_nettype wire
